// ===== sv/egcd_pkg.sv =====
// ---------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended gcd unit: control and status between the
// sequencer and the shared divide / multiply-accumulate unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package egcd_pkg;

  typedef struct packed {
    logic load;   // launch one quotient round
  } egcd_div_ctrl_t;

  typedef struct packed {
    logic busy;   // a round is in progress
    logic done;   // round finished, results valid this cycle and after
  } egcd_div_stat_t;

endpackage

// ===== sv/egcd_divstep.sv =====
// ---------------------------------------------------------------------------
// egcd_divstep
// Shared unit for one Euclid round: restoring division of r0 by r1, one
// quotient bit per cycle, with the quotient bits folded into two shift-add
// products q*s1 and q*c1 as they appear (msb first).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module egcd_divstep
  import egcd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  egcd_div_ctrl_t        ctrl,
  output egcd_div_stat_t        stat,
  input  logic [DATA_WIDTH-2:0] dividend,
  input  logic [DATA_WIDTH-2:0] divisor,
  input  logic [DATA_WIDTH-1:0] mult_s,
  input  logic [DATA_WIDTH-1:0] mult_c,
  output logic [DATA_WIDTH-2:0] remainder,
  output logic [DATA_WIDTH-1:0] prod_s,
  output logic [DATA_WIDTH-1:0] prod_c
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic                  running;
  logic                  done;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-2:0] rem;
  logic [DATA_WIDTH-2:0] dvd;
  logic [DATA_WIDTH-2:0] dvs;
  logic [DATA_WIDTH-1:0] ms;
  logic [DATA_WIDTH-1:0] mc;
  logic [DATA_WIDTH-1:0] acc_s;
  logic [DATA_WIDTH-1:0] acc_c;

  logic [DATA_WIDTH-1:0] trial;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] trial_sub;
  logic [DATA_WIDTH-2:0] rem_next;
  logic [DATA_WIDTH-1:0] acc_s_next;
  logic [DATA_WIDTH-1:0] acc_c_next;

  always_comb begin
    trial      = {rem, dvd[DATA_WIDTH-2]};
    qbit       = (trial >= {1'b0, dvs});
    trial_sub  = trial - {1'b0, dvs};
    rem_next   = qbit ? trial_sub[DATA_WIDTH-2:0] : trial[DATA_WIDTH-2:0];
    // shift-add product, wraps at the coefficient width
    acc_s_next = {acc_s[DATA_WIDTH-2:0], 1'b0} + (qbit ? ms : '0);
    acc_c_next = {acc_c[DATA_WIDTH-2:0], 1'b0} + (qbit ? mc : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.load && !running) begin
        running <= 1'b1;
        cnt     <= CW'(DATA_WIDTH - 1);
        rem     <= '0;
        dvd     <= dividend;
        dvs     <= divisor;
        ms      <= mult_s;
        mc      <= mult_c;
        acc_s   <= '0;
        acc_c   <= '0;
      end else if (running) begin
        rem   <= rem_next;
        dvd   <= {dvd[DATA_WIDTH-3:0], 1'b0};
        acc_s <= acc_s_next;
        acc_c <= acc_c_next;
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = running;
  assign stat.done = done;
  assign remainder = rem;
  assign prod_s    = acc_s;
  assign prod_c    = acc_c;

endmodule

// ===== sv/extended_gcd_unit.sv =====
// ---------------------------------------------------------------------------
// extended_gcd_unit
// Extended Euclidean algorithm: gcd of two non-negative operands and the
// signed Bezout coefficients u, v with u*a + v*b = gcd.
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  item in   start / busy     first_value, second_value
//  result    done (strobe)    gcd_value, coef_first, coef_second
//
//  An item is taken when start is high and busy is low; busy stays high
//  until the result strobe. Each Euclid round runs check, launch,
//  DATA_WIDTH-1 bit-serial divider steps that also form q*s1 and q*c1,
//  and write-back; an item takes up to 45 rounds for 31-bit operands.
//  b = 0 gives a result from the check state with no divider round.
//  Reset is synchronous and returns the unit to idle; the receiver cannot
//  stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended_gcd_unit
  import egcd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [DATA_WIDTH-2:0]        first_value,
  input  logic [DATA_WIDTH-2:0]        second_value,
  output logic                         done,
  output logic [DATA_WIDTH-2:0]        gcd_value,
  output logic signed [DATA_WIDTH-1:0] coef_first,
  output logic signed [DATA_WIDTH-1:0] coef_second
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LAUNCH,
    ST_WAIT
  } state_t;

  state_t                state;
  logic [DATA_WIDTH-2:0] r0;
  logic [DATA_WIDTH-2:0] r1;
  logic [DATA_WIDTH-1:0] s0;
  logic [DATA_WIDTH-1:0] s1;
  logic [DATA_WIDTH-1:0] c0;
  logic [DATA_WIDTH-1:0] c1;

  egcd_div_ctrl_t        div_ctrl;
  egcd_div_stat_t        div_stat;
  logic [DATA_WIDTH-2:0] div_rem;
  logic [DATA_WIDTH-1:0] div_prod_s;
  logic [DATA_WIDTH-1:0] div_prod_c;

  assign div_ctrl.load = (state == ST_LAUNCH) && !div_stat.busy;

  egcd_divstep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_divstep (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .stat     (div_stat),
    .dividend (r0),
    .divisor  (r1),
    .mult_s   (s1),
    .mult_c   (c1),
    .remainder(div_rem),
    .prod_s   (div_prod_s),
    .prod_c   (div_prod_c)
  );

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            r0    <= first_value;
            r1    <= second_value;
            s0    <= DATA_WIDTH'(1);
            s1    <= '0;
            c0    <= '0;
            c1    <= DATA_WIDTH'(1);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (r1 == '0) begin
            gcd_value   <= r0;
            coef_first  <= $signed(s0);
            coef_second <= $signed(c0);
            done        <= 1'b1;
            state       <= ST_IDLE;
          end else begin
            state <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          if (div_ctrl.load) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            // (r0, r1) <- (r1, r0 mod r1), coefficients likewise
            r0    <= r1;
            r1    <= div_rem;
            s0    <= s1;
            s1    <= s0 - div_prod_s;
            c0    <= c1;
            c1    <= c0 - div_prod_c;
            state <= ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
